>>> design/shs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef struct packed {
        logic [31:0] word;
        logic        fin;
    } t_qword;

    typedef enum logic [2:0] {
        F_IDLE, F_PAD, F_ZERO, F_LENHI, F_LENLO
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE, B_ROUND, B_ADD
    } t_back_state;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage
`default_nettype wire

>>> design/shs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module shs_fifo
    import shs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_qword i_data,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_qword      o_data
);

    t_qword           r_mem [QDepth];
    logic [QAw-1:0]   r_wp, r_rp;
    logic [QAw:0]     r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == QDepth[QAw:0]);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{QAw{1'b0}}, do_push} - {{QAw{1'b0}}, do_pop};
        end
    end

endmodule
`default_nettype wire

>>> design/shs_front.sv
`timescale 1ns / 1ps
`default_nettype none
module shs_front
    import shs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_has_byte,
    input  wire logic       i_end_of_message,
    output logic            o_q_push,
    output t_qword          o_q_data,
    input  wire logic       i_q_full
);

    t_front_state r_state, n_state;
    logic [31:0]  r_word, n_word;
    logic [1:0]   r_nb, n_nb;
    logic [3:0]   r_wc, n_wc;
    logic [63:0]  r_bits, n_bits;
    logic [4:0]   sh;
    logic [31:0]  with_byte;
    logic         acc;

    assign o_full    = (r_state != F_IDLE) || i_q_full;
    assign acc       = i_push && !o_full;
    // big-endian: byte 0 of a word sits in bits 31:24
    assign sh        = {~r_nb, 3'b000};
    assign with_byte = r_word | ({24'b0, i_data_byte} << sh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_word  <= '0;
            r_nb    <= '0;
            r_wc    <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_nb    <= n_nb;
            r_wc    <= n_wc;
            r_bits  <= n_bits;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_nb     = r_nb;
        n_wc     = r_wc;
        n_bits   = r_bits;
        o_q_push = 1'b0;
        o_q_data = '{word: r_word, fin: 1'b0};
        unique case (r_state)
            F_IDLE: begin
                if (acc) begin
                    if (i_has_byte) begin
                        n_bits = r_bits + 64'd8;
                        if (r_nb == 2'd3) begin
                            o_q_push = 1'b1;
                            o_q_data = '{word: with_byte, fin: 1'b0};
                            n_word   = '0;
                            n_nb     = '0;
                            n_wc     = r_wc + 4'd1;
                        end else begin
                            n_word = with_byte;
                            n_nb   = r_nb + 2'd1;
                        end
                    end
                    if (i_end_of_message) n_state = F_PAD;
                end
            end
            F_PAD: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_q_data = '{word: r_word | (32'h80 << sh), fin: 1'b0};
                    n_word   = '0;
                    n_nb     = '0;
                    n_wc     = r_wc + 4'd1;
                    n_state  = (r_wc + 4'd1 == 4'd14) ? F_LENHI : F_ZERO;
                end
            end
            F_ZERO: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_q_data = '{word: 32'h0, fin: 1'b0};
                    n_wc     = r_wc + 4'd1;
                    if (r_wc + 4'd1 == 4'd14) n_state = F_LENHI;
                end
            end
            F_LENHI: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_q_data = '{word: r_bits[63:32], fin: 1'b0};
                    n_wc     = r_wc + 4'd1;
                    n_state  = F_LENLO;
                end
            end
            F_LENLO: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_q_data = '{word: r_bits[31:0], fin: 1'b1};
                    n_wc     = '0;
                    n_bits   = '0;
                    n_state  = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> design/shs_back.sv
`timescale 1ns / 1ps
`default_nettype none
module shs_back
    import shs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  wire t_qword i_q_data,
    output logic        o_q_pop,
    output logic        o_empty,
    input  wire logic   i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_back_state  r_state, n_state;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [31:0]  r_dig [8];
    logic [5:0]   r_rnd;
    logic         r_fin;
    logic         r_busy;
    logic [2:0]   r_idx;
    logic         step, load, finish, emit;
    logic [31:0]  w, t1, t2;

    assign o_empty       = !r_busy;
    assign o_digest_word = r_dig[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    always_comb begin
        if (r_rnd < 6'd16) begin
            w = i_q_data.word;
        end else begin
            w = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
        end
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + KTAB[r_rnd] + w;
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_state = r_state;
        step    = 1'b0;
        load    = 1'b0;
        finish  = 1'b0;
        emit    = 1'b0;
        o_q_pop = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    load    = 1'b1;
                    n_state = B_ROUND;
                end
            end
            B_ROUND: begin
                if (r_rnd >= 6'd16 || i_q_valid) begin
                    step    = 1'b1;
                    o_q_pop = (r_rnd < 6'd16);
                    if (r_rnd == 6'd63) n_state = B_ADD;
                end
            end
            B_ADD: begin
                // a final block waits until the previous digest has drained
                if (!r_fin || !r_busy) begin
                    finish  = 1'b1;
                    emit    = r_fin;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_v <= r_h;
        end else if (step) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
        if (step) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k+1];
            r_w[15] <= w;
        end
        if (emit) begin
            for (int k = 0; k < 8; k++) r_dig[k] <= r_h[k] + r_v[k];
        end
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_h     <= IV;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_rnd <= '0;
                r_fin <= 1'b0;
            end else if (step) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd < 6'd16) r_fin <= r_fin | i_q_data.fin;
            end
            if (finish) begin
                if (r_fin) begin
                    r_h <= IV;
                end else begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                end
            end
            if (emit) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && i_pop) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) r_busy <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/sha256_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 over a byte stream.
// Input queue: i_push / o_full, one beat per message byte. i_has_byte marks a
// beat that carries a byte; i_end_of_message on the last beat of a message
// (which may carry no byte, so empty messages work).
// Output queue: o_empty / i_pop. Each digest gives eight beats, word 0 first,
// o_last_word on word 7; the word is the big-endian value of h[word_index].
// Bytes are taken at one per cycle, while o_full is low, into a word packer
// feeding a four-word queue; the round engine pulls one word per round for the
// first 16 rounds. A block passes through load, 64 rounds and a chain add
// once its words are there, all in the single shared round unit. The queue
// holds only 16 bytes, so intake stalls while the engine runs its rounds past
// round 15 and finishes the block.
// After the end beat o_full stays high while padding and the length are
// queued, and longer while a stalled receiver holds the previous digest. The
// first digest word is ready once the final block has run its rounds and
// chain add.
// If the receiver stalls, the digest is held; a following message is still
// absorbed until its own final block needs the output bank.
// Reset (synchronous, active low) clears the queues and restores the initial
// chaining values.
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    logic   q_push, q_full, q_pop, q_valid;
    t_qword q_in, q_out;

    shs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_q_push         (q_push),
        .o_q_data         (q_in),
        .i_q_full         (q_full)
    );

    shs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    shs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule
`default_nettype wire
